// ===== design/uart_rb_pkg.sv =====
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared types and constants for the buffered serial port core: ring depths,
// pointer widths, event codes, request and response beats, control commands.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

   localparam int RX_DEPTH  = 32;
   localparam int TX_DEPTH  = 32;
   localparam int RX_PTR_W  = $clog2(RX_DEPTH);
   localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
   localparam int TX_PTR_W  = $clog2(TX_DEPTH);
   localparam int TX_CNT_W  = $clog2(TX_DEPTH + 1);

   typedef enum logic [1:0] {
      FUNC_RX_BYTE = 2'd0,
      FUNC_TX_DONE = 2'd1,
      FUNC_HOST_RD = 2'd2,
      FUNC_HOST_WR = 2'd3
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic        line_valid;
      logic [7:0]  line_byte;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic        write_rejected;
      logic        rx_dropped;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic        exec;
   } cmd_type;

endpackage

// ===== design/uart_rb_ctrl.sv =====
// ----------------------------------------------------------------------------
// uart_rb_ctrl
// Handshake controller: take one request beat, hold the result beat until
// the consumer takes it, then return to idle.
// ----------------------------------------------------------------------------
module uart_rb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output uart_rb_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RESP = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.exec  = req_valid && (state_ff == ST_IDLE);

endmodule

// ===== design/uart_rb_datapath.sv =====
// ----------------------------------------------------------------------------
// uart_rb_datapath
// Receive ring and transmit queue: memories, positions, transmitter idle
// flag, and the registered result of the last executed event.
// ----------------------------------------------------------------------------
module uart_rb_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  uart_rb_pkg::cmd_type cmd,
   input  uart_rb_pkg::req_type req,
   output uart_rb_pkg::rsp_type rsp
);

   localparam int RXW  = uart_rb_pkg::RX_PTR_W;
   localparam int RXFW = uart_rb_pkg::RX_FILL_W;
   localparam int TXW  = uart_rb_pkg::TX_PTR_W;
   localparam int TXCW = uart_rb_pkg::TX_CNT_W;
   localparam logic [RXFW-1:0] RX_FULL  = RXFW'(uart_rb_pkg::RX_DEPTH);
   localparam logic [RXW-1:0]  RX_LAST  = RXW'(uart_rb_pkg::RX_DEPTH - 1);
   localparam logic [TXW-1:0]  TX_LAST  = TXW'(uart_rb_pkg::TX_DEPTH - 1);
   localparam logic [TXCW-1:0] TX_FULL  = TXCW'(uart_rb_pkg::TX_DEPTH);

   logic [7:0] rx_mem [uart_rb_pkg::RX_DEPTH];
   logic [7:0] tx_mem [uart_rb_pkg::TX_DEPTH];

   logic [RXFW-1:0] rx_fill_ff, rx_fill_in;
   logic [RXW-1:0]  rx_take_ff, rx_take_in;
   logic [TXW-1:0]  tx_tail_ff, tx_tail_in;
   logic [TXW-1:0]  tx_head_ff, tx_head_in;
   logic [TXCW-1:0] tx_count_ff, tx_count_in;
   logic            tx_idle_ff, tx_idle_in;

   // Result registers, loaded once per executed event.
   logic            line_valid_ff, line_valid_in;
   logic            line_mem_ff, line_mem_in;
   logic [7:0]      line_direct_ff;
   logic            read_valid_ff, read_valid_in;
   logic            reject_ff, reject_in;
   logic            drop_ff, drop_in;
   logic [7:0]      rx_rd_ff;
   logic [7:0]      tx_rd_ff;

   logic            rx_wr, tx_wr, rx_rd, tx_rd;
   logic [RXW-1:0]  rx_fill_next;

   always_comb begin
      rx_fill_in    = rx_fill_ff;
      rx_take_in    = rx_take_ff;
      tx_tail_in    = tx_tail_ff;
      tx_head_in    = tx_head_ff;
      tx_count_in   = tx_count_ff;
      tx_idle_in    = tx_idle_ff;
      line_valid_in = 1'b0;
      line_mem_in   = 1'b0;
      read_valid_in = 1'b0;
      reject_in     = 1'b0;
      drop_in       = 1'b0;
      rx_wr         = 1'b0;
      tx_wr         = 1'b0;
      rx_rd         = 1'b0;
      tx_rd         = 1'b0;
      rx_fill_next  = (rx_fill_ff[RXW-1:0] == RX_LAST) ? '0 : rx_fill_ff[RXW-1:0] + 1'b1;

      case (req.func)
         uart_rb_pkg::FUNC_RX_BYTE: begin
            if (rx_fill_ff != RX_FULL) begin
               rx_wr = 1'b1;
               if (rx_fill_next == rx_take_ff) rx_fill_in = RX_FULL;
               else                            rx_fill_in = RXFW'(rx_fill_next);
            end else begin
               drop_in = 1'b1;
            end
         end
         uart_rb_pkg::FUNC_TX_DONE: begin
            if (!tx_idle_ff && tx_count_ff != '0) begin
               line_valid_in = 1'b1;
               line_mem_in   = 1'b1;
               tx_rd         = 1'b1;
               tx_head_in    = (tx_head_ff == TX_LAST) ? '0 : tx_head_ff + 1'b1;
               tx_count_in   = tx_count_ff - 1'b1;
            end else begin
               tx_idle_in = 1'b1;
            end
         end
         uart_rb_pkg::FUNC_HOST_RD: begin
            if (RXFW'(rx_take_ff) != rx_fill_ff) begin
               read_valid_in = 1'b1;
               rx_rd         = 1'b1;
               rx_take_in    = (rx_take_ff == RX_LAST) ? '0 : rx_take_ff + 1'b1;
               // Full ring: reopen the fill position on the freed slot.
               if (rx_fill_ff == RX_FULL) rx_fill_in = RXFW'(rx_take_ff);
            end
         end
         default: begin
            if (tx_idle_ff) begin
               tx_idle_in    = 1'b0;
               line_valid_in = 1'b1;
            end else if (tx_count_ff == TX_FULL) begin
               reject_in = 1'b1;
            end else begin
               tx_wr       = 1'b1;
               tx_tail_in  = (tx_tail_ff == TX_LAST) ? '0 : tx_tail_ff + 1'b1;
               tx_count_in = tx_count_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_fill_ff  <= '0;
         rx_take_ff  <= '0;
         tx_tail_ff  <= '0;
         tx_head_ff  <= '0;
         tx_count_ff <= '0;
         tx_idle_ff  <= 1'b1;
      end else if (cmd.exec) begin
         rx_fill_ff  <= rx_fill_in;
         rx_take_ff  <= rx_take_in;
         tx_tail_ff  <= tx_tail_in;
         tx_head_ff  <= tx_head_in;
         tx_count_ff <= tx_count_in;
         tx_idle_ff  <= tx_idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         line_valid_ff  <= line_valid_in;
         line_mem_ff    <= line_mem_in;
         line_direct_ff <= req.data_byte;
         read_valid_ff  <= read_valid_in;
         reject_ff      <= reject_in;
         drop_ff        <= drop_in;
      end
   end

   // Receive ring memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.exec && rx_wr) rx_mem[rx_fill_ff[RXW-1:0]] <= req.data_byte;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && rx_rd) rx_rd_ff <= rx_mem[rx_take_ff];
   end

   // Transmit queue memory.
   always_ff @(posedge clock) begin
      if (cmd.exec && tx_wr) tx_mem[tx_tail_ff] <= req.data_byte;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && tx_rd) tx_rd_ff <= tx_mem[tx_head_ff];
   end

   always_comb begin
      rsp.line_valid     = line_valid_ff;
      rsp.line_byte      = !line_valid_ff ? 8'h00 : (line_mem_ff ? tx_rd_ff : line_direct_ff);
      rsp.read_valid     = read_valid_ff;
      rsp.read_byte      = read_valid_ff ? rx_rd_ff : 8'h00;
      rsp.write_rejected = reject_ff;
      rsp.rx_dropped     = drop_ff;
   end

endmodule

// ===== design/uart_rb_unit_top.sv =====
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_unit
// Buffered serial port core: receive ring and transmit queue, one event per
// request beat, one result beat per event.
// ----------------------------------------------------------------------------
// Response: the result beat is offered in the cycle after the request beat is accepted.
// Flow: a new request beat is accepted only after the result beat is taken;
//   the memory access and pointer update of one event finish before the next.
// Reset: synchronous, active high; clears positions and count and sets the
//   idle flag (transmitter idle). Ring memories are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  uart_rb_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output uart_rb_pkg::rsp_type rsp_payload
);

   // Single command from controller: execute the accepted event this cycle.
   uart_rb_pkg::cmd_type cmd;

   // Controller: accept one beat, hold the result until it is taken.
   uart_rb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: both rings, their positions, and the registered result.
   // The result registers load only on execute, so the payload holds while
   // the result beat stalls.
   uart_rb_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_payload),
      .rsp   (rsp_payload)
   );

endmodule
